// ----- rtl/swarq_pkg.sv -----
package swarq_pkg;

  // event codes
  localparam logic [1:0] FUNC_SEND    = 2'd0;
  localparam logic [1:0] FUNC_FRAME   = 2'd1;
  localparam logic [1:0] FUNC_TIMEOUT = 2'd2;
  localparam logic [1:0] FUNC_EPOCH   = 2'd3;

  // received frame kinds
  localparam logic [1:0] FRAME_DATA = 2'd0;
  localparam logic [1:0] FRAME_ACK  = 2'd1;

  // emitted frame kinds
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_ACK  = 2'd2;

  // timeout status codes
  localparam logic [1:0] TMO_IDLE    = 2'd0;
  localparam logic [1:0] TMO_FAILED  = 2'd1;
  localparam logic [1:0] TMO_RETRIED = 2'd2;
  localparam logic [1:0] TMO_NONE    = 2'd3;

  // configuration register indexes
  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_RETRY_CAP = 1'd0;
  localparam cfg_idx_t CFG_TX_PATH   = 1'd1;

  localparam logic [7:0] RETRY_CAP_RESET = 8'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] send_len;
    logic [1:0]  frame_type;
    logic [7:0]  frame_sequence;
    logic [7:0]  frame_payload_length;
    logic        consumer_accepts;
  } item_t;

  typedef struct packed {
    logic       send_accepted;
    logic [1:0] transmit_kind;
    logic       transmit_seq_bit;
    logic       payload_delivered;
    logic [1:0] timeout_status;
    logic       awaiting_ack;
  } result_t;

  typedef struct packed {
    logic       waiting;
    logic       tx_seq;
    logic       rx_seq;
    logic [7:0] retry_count;
  } link_state_t;

  typedef struct packed {
    logic [7:0] retry_cap;
    logic       tx_path_present;
  } cfg_t;

  localparam link_state_t STATE_RESET = '{waiting: 1'b0, tx_seq: 1'b0, rx_seq: 1'b0,
                                         retry_count: 8'd0};

endpackage

// ----- rtl/swarq_if.sv -----
interface swarq_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] send_len;
  logic [1:0]  frame_type;
  logic [7:0]  frame_sequence;
  logic [7:0]  frame_payload_length;
  logic        consumer_accepts;

  modport source (
    output valid, func, send_len, frame_type, frame_sequence,
           frame_payload_length, consumer_accepts,
    input  ready
  );
  modport sink (
    input  valid, func, send_len, frame_type, frame_sequence,
           frame_payload_length, consumer_accepts,
    output ready
  );
endinterface

interface swarq_rsp_if;
  logic       valid;
  logic       ready;
  logic       send_accepted;
  logic [1:0] transmit_kind;
  logic       transmit_seq_bit;
  logic       payload_delivered;
  logic [1:0] timeout_status;
  logic       awaiting_ack;

  modport source (
    output valid, send_accepted, transmit_kind, transmit_seq_bit,
           payload_delivered, timeout_status, awaiting_ack,
    input  ready
  );
  modport sink (
    input  valid, send_accepted, transmit_kind, transmit_seq_bit,
           payload_delivered, timeout_status, awaiting_ack,
    output ready
  );
endinterface

// ----- rtl/swarq_cfg.sv -----
module swarq_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  swarq_pkg::cfg_idx_t cfg_index,
  input  logic [7:0]        cfg_data,
  output swarq_pkg::cfg_t   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.retry_cap       <= swarq_pkg::RETRY_CAP_RESET;
      cfg.tx_path_present <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        swarq_pkg::CFG_RETRY_CAP: cfg.retry_cap       <= cfg_data;
        swarq_pkg::CFG_TX_PATH:   cfg.tx_path_present <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/swarq_core.sv -----
module swarq_core #(
  parameter int unsigned MAX_PAYLOAD = 64
) (
  input  swarq_pkg::item_t       item,
  input  swarq_pkg::link_state_t state,
  input  swarq_pkg::cfg_t        cfg,
  output swarq_pkg::result_t     result,
  output swarq_pkg::link_state_t state_next
);

  logic ack_match;
  logic seq_expected;
  logic seq_duplicate;

  assign ack_match     = (item.frame_payload_length == 8'd0) && state.waiting &&
                         (item.frame_sequence == {7'd0, state.tx_seq});
  assign seq_expected  = (item.frame_sequence == {7'd0, state.rx_seq});
  assign seq_duplicate = (item.frame_sequence == {7'd0, ~state.rx_seq});

  always_comb begin
    state_next = state;
    result.send_accepted     = 1'b0;
    result.transmit_kind     = swarq_pkg::KIND_NONE;
    result.transmit_seq_bit  = 1'b0;
    result.payload_delivered = 1'b0;
    result.timeout_status    = swarq_pkg::TMO_NONE;

    unique case (item.func)
      swarq_pkg::FUNC_SEND: begin
        if (!state.waiting && cfg.tx_path_present &&
            item.send_len <= 16'(MAX_PAYLOAD)) begin
          state_next.retry_count  = 8'd0;
          state_next.waiting      = 1'b1;
          result.send_accepted    = 1'b1;
          result.transmit_kind    = swarq_pkg::KIND_DATA;
          result.transmit_seq_bit = state.tx_seq;
        end
      end
      swarq_pkg::FUNC_FRAME: begin
        if (item.frame_type == swarq_pkg::FRAME_ACK) begin
          if (ack_match) begin
            state_next.waiting = 1'b0;
            state_next.tx_seq  = ~state.tx_seq;
          end
        end else if (item.frame_type == swarq_pkg::FRAME_DATA) begin
          if (seq_expected) begin
            if (item.consumer_accepts) begin
              result.payload_delivered = 1'b1;
              state_next.rx_seq        = ~state.rx_seq;
              result.transmit_kind     = swarq_pkg::KIND_ACK;
              result.transmit_seq_bit  = item.frame_sequence[0];
            end
          end else if (seq_duplicate) begin
            // duplicate: re-ack, drop the payload
            result.transmit_kind    = swarq_pkg::KIND_ACK;
            result.transmit_seq_bit = item.frame_sequence[0];
          end
        end
      end
      swarq_pkg::FUNC_TIMEOUT: begin
        if (!state.waiting) begin
          result.timeout_status = swarq_pkg::TMO_IDLE;
        end else if (state.retry_count >= cfg.retry_cap) begin
          state_next.waiting    = 1'b0;
          result.timeout_status = swarq_pkg::TMO_FAILED;
        end else begin
          state_next.retry_count  = state.retry_count + 8'd1;
          result.transmit_kind    = swarq_pkg::KIND_DATA;
          result.transmit_seq_bit = state.tx_seq;
          result.timeout_status   = swarq_pkg::TMO_RETRIED;
        end
      end
      swarq_pkg::FUNC_EPOCH: begin
        state_next = swarq_pkg::STATE_RESET;
      end
      default: state_next = state;
    endcase

    result.awaiting_ack = state_next.waiting;
  end

endmodule

// ----- rtl/stop_and_wait_arq_link_unit.sv -----
// Alternating-bit stop-and-wait link controller. Every event item (send request,
// received frame, timeout tick, epoch reset) gives exactly one result item.
// Throughput is one item per clock while the result side is ready: the link state is
// read and updated in a single cycle between the input register and the result register.
// An accepted item passes the input register and then the result register, and the
// result leaves at the first edge at which the result side is ready; a held result
// holds the input register, and input stalls once both registers are full.
// Configuration (index 0 retry cap, index 1 transmit path present) is to be written
// by the user only while no item is in flight; the block itself does not enforce it.
module stop_and_wait_arq_link_unit #(
  parameter int unsigned MAX_PAYLOAD = 64
) (
  input  logic                clk,
  input  logic                rst,
  swarq_req_if.sink           req,
  swarq_rsp_if.source         rsp,
  input  logic                cfg_we,
  input  swarq_pkg::cfg_idx_t cfg_index,
  input  logic [7:0]          cfg_data
);

  swarq_pkg::cfg_t        cfg;
  swarq_pkg::item_t       item;
  logic                   item_vld;
  swarq_pkg::link_state_t state;
  swarq_pkg::link_state_t state_next;
  swarq_pkg::result_t     result;
  swarq_pkg::result_t     out_q;
  logic                   out_vld;
  logic                   advance;
  logic                   take;

  swarq_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  swarq_core #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_core (
    .item       (item),
    .state      (state),
    .cfg        (cfg),
    .result     (result),
    .state_next (state_next)
  );

  assign advance   = item_vld && (!out_vld || rsp.ready);
  assign req.ready = !item_vld || advance;
  assign take      = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld <= 1'b0;
      out_vld  <= 1'b0;
      state    <= swarq_pkg::STATE_RESET;
    end else begin
      if (take) begin
        item_vld <= 1'b1;
      end else if (advance) begin
        item_vld <= 1'b0;
      end
      if (advance) begin
        out_vld <= 1'b1;
        state   <= state_next;
      end else if (rsp.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.func                 <= req.func;
      item.send_len             <= req.send_len;
      item.frame_type           <= req.frame_type;
      item.frame_sequence       <= req.frame_sequence;
      item.frame_payload_length <= req.frame_payload_length;
      item.consumer_accepts     <= req.consumer_accepts;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  assign rsp.valid             = out_vld;
  assign rsp.send_accepted     = out_q.send_accepted;
  assign rsp.transmit_kind     = out_q.transmit_kind;
  assign rsp.transmit_seq_bit  = out_q.transmit_seq_bit;
  assign rsp.payload_delivered = out_q.payload_delivered;
  assign rsp.timeout_status    = out_q.timeout_status;
  assign rsp.awaiting_ack      = out_q.awaiting_ack;

  a_send_sets_wait: assert property (@(posedge clk) disable iff (rst)
    out_vld && out_q.send_accepted |-> out_q.awaiting_ack && state.waiting)
    else $error("accepted send did not leave the link waiting for ack");

  a_deliver_acks: assert property (@(posedge clk) disable iff (rst)
    out_vld && out_q.payload_delivered |-> out_q.transmit_kind == swarq_pkg::KIND_ACK)
    else $error("delivered item was not acked");

  a_retry_emits_data: assert property (@(posedge clk) disable iff (rst)
    out_vld && out_q.timeout_status == swarq_pkg::TMO_RETRIED |->
      out_q.transmit_kind == swarq_pkg::KIND_DATA && out_q.awaiting_ack)
    else $error("retry did not re-emit the data frame");

  a_state_on_advance: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state))
    else $error("link state changed without an item");

endmodule
